@@ rtl/dklt_pkg.sv @@
// Shared constants, types and codes of the decaying key level table.
package dklt_pkg;

    localparam int NUM_KEYS   = 128;
    localparam int LEVEL_BITS = 16;
    localparam int TAG_BITS   = 16;

    localparam int IDX_W     = $clog2(NUM_KEYS);
    localparam int KEY_W     = 7;
    localparam int FIELD_W   = 16;
    localparam int CMD_W     = 2;
    localparam int TICK_W    = 4;
    localparam int ACT_W     = 3;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W     = ((LEVEL_BITS > FIELD_W) ? LEVEL_BITS : FIELD_W) + 1;
    localparam int PROD_W    = LEVEL_BITS + FIELD_W;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [TAG_BITS-1:0]   t_tag;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [CMP_W-1:0]      t_cmp;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [TICK_W-1:0]     t_ticks;

    typedef enum logic [CMD_W-1:0] {
        CMD_REPORT = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERTED    = 3'd0,
        ACT_UPDATED     = 3'd1,
        ACT_RETRIGGERED = 3'd2,
        ACT_REMOVED     = 3'd3,
        ACT_IGNORED     = 3'd4,
        ACT_TICK_DONE   = 3'd5,
        ACT_READ        = 3'd6
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 2'd2;

    localparam t_field RETENTION_RST = 16'd65292;
    localparam t_field THRESHOLD_RST = 16'd512;
    localparam t_field MARGIN_RST    = 16'd13107;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_TICK_SCAN,
        ST_TICK_LOAD,
        ST_TICK_MUL,
        ST_TICK_WB,
        ST_TICK_END,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic lookup;
        logic decide;
        logic scan_rd;
        logic scan_next;
        logic load_v;
        logic mul;
        logic wb;
        logic tick_end;
        logic emit;
    } t_dp_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic idx_valid;
        logic idx_last;
        logic ticks_zero;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        t_action action;
        t_key    key;
        logic    present;
        t_field  level;
        t_field  tag;
        t_cnt    removed;
        t_cnt    remaining;
    } t_result;

endpackage

@@ rtl/dklt_ram.sv @@
// Generic simple dual-port RAM with registered read.
module dklt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dklt_ctrl.sv @@
// Controller state machine: sequences lookups, decisions, the tick sweep and result hand-off.
module dklt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dklt_pkg::t_cmd    i_in_cmd,
    output logic              o_in_ready,
    input  dklt_pkg::t_dp_sts i_sts,
    output dklt_pkg::t_dp_ctl o_ctl
);

    dklt_pkg::t_state r_state;
    dklt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dklt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dklt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_cmd == dklt_pkg::CMD_TICK) ? dklt_pkg::ST_TICK_SCAN
                                                               : dklt_pkg::ST_LOOKUP;
                end
            end
            dklt_pkg::ST_LOOKUP: n_state = dklt_pkg::ST_DECIDE;
            dklt_pkg::ST_DECIDE: n_state = dklt_pkg::ST_EMIT;
            dklt_pkg::ST_TICK_SCAN: begin
                if (i_sts.idx_valid) begin
                    n_state = dklt_pkg::ST_TICK_LOAD;
                end else if (i_sts.idx_last) begin
                    n_state = dklt_pkg::ST_TICK_END;
                end
            end
            dklt_pkg::ST_TICK_LOAD: n_state = dklt_pkg::ST_TICK_MUL;
            dklt_pkg::ST_TICK_MUL: begin
                if (i_sts.ticks_zero) begin
                    n_state = dklt_pkg::ST_TICK_WB;
                end
            end
            dklt_pkg::ST_TICK_WB: begin
                n_state = i_sts.idx_last ? dklt_pkg::ST_TICK_END : dklt_pkg::ST_TICK_SCAN;
            end
            dklt_pkg::ST_TICK_END: n_state = dklt_pkg::ST_EMIT;
            dklt_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = dklt_pkg::ST_IDLE;
                end
            end
            default: n_state = dklt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dklt_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.accept = i_in_valid;
            end
            dklt_pkg::ST_LOOKUP: o_ctl.lookup = 1'b1;
            dklt_pkg::ST_DECIDE: o_ctl.decide = 1'b1;
            dklt_pkg::ST_TICK_SCAN: begin
                o_ctl.scan_rd   = i_sts.idx_valid;
                o_ctl.scan_next = !i_sts.idx_valid && !i_sts.idx_last;
            end
            dklt_pkg::ST_TICK_LOAD: o_ctl.load_v = 1'b1;
            dklt_pkg::ST_TICK_MUL: o_ctl.mul = !i_sts.ticks_zero;
            dklt_pkg::ST_TICK_WB: begin
                o_ctl.wb        = 1'b1;
                o_ctl.scan_next = !i_sts.idx_last;
            end
            dklt_pkg::ST_TICK_END: o_ctl.tick_end = 1'b1;
            dklt_pkg::ST_EMIT: o_ctl.emit = i_sts.out_free;
            default: o_ctl = '0;
        endcase
    end

endmodule

@@ rtl/dklt_dp.sv @@
// Datapath: configuration, request latch, valid bits, level and tag RAMs, decay multiplier,
// tick counters and the result register.
module dklt_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dklt_pkg::t_dp_ctl     i_ctl,
    output dklt_pkg::t_dp_sts     o_sts,
    input  dklt_pkg::t_cmd        i_cmd,
    input  dklt_pkg::t_key        i_key,
    input  dklt_pkg::t_field      i_level,
    input  dklt_pkg::t_field      i_tag,
    input  dklt_pkg::t_ticks      i_ticks,
    input  logic                  i_cfg_valid,
    input  logic [dklt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  dklt_pkg::t_field      i_cfg_data,
    output dklt_pkg::t_result     o_out,
    output logic                  o_out_valid,
    input  logic                  i_out_ready
);

    dklt_pkg::t_field  r_retention;
    dklt_pkg::t_field  r_threshold;
    dklt_pkg::t_field  r_margin;

    dklt_pkg::t_cmd    r_cmd;
    dklt_pkg::t_key    r_key;
    dklt_pkg::t_level  r_level;
    dklt_pkg::t_tag    r_tag;
    dklt_pkg::t_ticks  r_ticks;

    logic [dklt_pkg::NUM_KEYS-1:0] r_valid;
    dklt_pkg::t_idx    r_idx;
    dklt_pkg::t_level  r_v;
    dklt_pkg::t_ticks  r_t;
    dklt_pkg::t_cnt    r_removed;
    dklt_pkg::t_cnt    r_remaining;

    dklt_pkg::t_result r_res;
    dklt_pkg::t_result n_res;
    dklt_pkg::t_result r_out;
    logic              r_out_valid;

    dklt_pkg::t_level  lvl_rdata;
    dklt_pkg::t_tag    tag_rdata;

    dklt_pkg::t_idx    key_idx;
    logic              key_ok;
    logic              here;
    dklt_pkg::t_cmp    lvl_c;
    dklt_pkg::t_cmp    thr_c;
    dklt_pkg::t_cmp    sum_c;
    logic [dklt_pkg::PROD_W-1:0] prod;
    logic              prune_v;

    logic              dec_set;
    logic              dec_clr;
    logic              dec_we_lvl;
    logic              dec_we_tag;

    logic              lvl_we;
    dklt_pkg::t_idx    lvl_waddr;
    dklt_pkg::t_level  lvl_wdata;
    logic              rd_en;
    dklt_pkg::t_idx    rd_addr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retention <= dklt_pkg::RETENTION_RST;
            r_threshold <= dklt_pkg::THRESHOLD_RST;
            r_margin    <= dklt_pkg::MARGIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dklt_pkg::CFG_RETENTION: r_retention <= i_cfg_data;
                dklt_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                dklt_pkg::CFG_MARGIN:    r_margin    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign key_idx = dklt_pkg::t_idx'(r_key);
    assign key_ok  = (32'(r_key) < 32'(dklt_pkg::NUM_KEYS));
    assign here    = key_ok && r_valid[key_idx];
    assign lvl_c   = dklt_pkg::t_cmp'(r_level);
    assign thr_c   = dklt_pkg::t_cmp'(r_threshold);
    assign sum_c   = dklt_pkg::t_cmp'(lvl_rdata) + dklt_pkg::t_cmp'(r_margin);
    assign prod    = r_v * r_retention;
    assign prune_v = dklt_pkg::t_cmp'(r_v) < thr_c;

    // decision for a report, read or unused command, and the tick-done result
    always_comb begin
        n_res            = '0;
        n_res.action     = dklt_pkg::ACT_IGNORED;
        n_res.key        = r_key;
        dec_set          = 1'b0;
        dec_clr          = 1'b0;
        dec_we_lvl       = 1'b0;
        dec_we_tag       = 1'b0;
        if (i_ctl.tick_end) begin
            n_res.action    = dklt_pkg::ACT_TICK_DONE;
            n_res.key       = '0;
            n_res.removed   = r_removed;
            n_res.remaining = r_remaining;
        end else if (r_cmd == dklt_pkg::CMD_REPORT) begin
            if (!key_ok) begin
                n_res.action = dklt_pkg::ACT_IGNORED;
            end else if (!here) begin
                if (r_level != '0) begin
                    n_res.action  = dklt_pkg::ACT_INSERTED;
                    n_res.present = 1'b1;
                    n_res.level   = dklt_pkg::t_field'(r_level);
                    n_res.tag     = dklt_pkg::t_field'(r_tag);
                    dec_set       = 1'b1;
                    dec_we_lvl    = 1'b1;
                    dec_we_tag    = 1'b1;
                end
            end else if (lvl_c < thr_c) begin
                n_res.action = dklt_pkg::ACT_REMOVED;
                dec_clr      = 1'b1;
            end else if (lvl_c < sum_c) begin
                n_res.action  = dklt_pkg::ACT_UPDATED;
                n_res.present = 1'b1;
                n_res.level   = dklt_pkg::t_field'(r_level);
                n_res.tag     = dklt_pkg::t_field'(tag_rdata);
                dec_we_lvl    = 1'b1;
            end else begin
                n_res.action  = dklt_pkg::ACT_RETRIGGERED;
                n_res.present = 1'b1;
                n_res.level   = dklt_pkg::t_field'(r_level);
                n_res.tag     = dklt_pkg::t_field'(r_tag);
                dec_we_lvl    = 1'b1;
                dec_we_tag    = 1'b1;
            end
        end else begin
            n_res.action = (r_cmd == dklt_pkg::CMD_READ) ? dklt_pkg::ACT_READ
                                                         : dklt_pkg::ACT_IGNORED;
            if (here) begin
                n_res.present = 1'b1;
                n_res.level   = dklt_pkg::t_field'(lvl_rdata);
                n_res.tag     = dklt_pkg::t_field'(tag_rdata);
            end
        end
    end

    // RAM port selection
    assign rd_en     = i_ctl.lookup || i_ctl.scan_rd;
    assign rd_addr   = i_ctl.scan_rd ? r_idx : key_idx;
    assign lvl_we    = (i_ctl.decide && dec_we_lvl) || (i_ctl.wb && !prune_v);
    assign lvl_waddr = i_ctl.wb ? r_idx : key_idx;
    assign lvl_wdata = i_ctl.wb ? r_v : r_level;

    dklt_ram #(
        .WIDTH (dklt_pkg::LEVEL_BITS),
        .DEPTH (dklt_pkg::NUM_KEYS)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (lvl_rdata)
    );

    dklt_ram #(
        .WIDTH (dklt_pkg::TAG_BITS),
        .DEPTH (dklt_pkg::NUM_KEYS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.decide && dec_we_tag),
        .i_waddr (key_idx),
        .i_wdata (r_tag),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (tag_rdata)
    );

    // request latch and decay working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd   <= i_cmd;
            r_key   <= i_key;
            r_level <= dklt_pkg::t_level'(i_level);
            r_tag   <= dklt_pkg::t_tag'(i_tag);
            r_ticks <= i_ticks;
        end
        if (i_ctl.load_v) begin
            r_v <= lvl_rdata;
            r_t <= r_ticks;
        end else if (i_ctl.mul) begin
            r_v <= prod[dklt_pkg::PROD_W-1:dklt_pkg::FIELD_W];
            r_t <= r_t - 1'b1;
        end
        if (i_ctl.decide || i_ctl.tick_end) begin
            r_res <= n_res;
        end
    end

    // valid bits, sweep index and tick counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_idx       <= '0;
            r_removed   <= '0;
            r_remaining <= '0;
        end else begin
            if (i_ctl.accept) begin
                r_idx       <= '0;
                r_removed   <= '0;
                r_remaining <= '0;
            end else if (i_ctl.scan_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctl.decide && dec_set) begin
                r_valid[key_idx] <= 1'b1;
            end
            if (i_ctl.decide && dec_clr) begin
                r_valid[key_idx] <= 1'b0;
            end
            if (i_ctl.wb) begin
                if (prune_v) begin
                    r_valid[r_idx] <= 1'b0;
                    if (r_removed != '1) begin
                        r_removed <= r_removed + 1'b1;
                    end
                end else if (r_remaining != '1) begin
                    r_remaining <= r_remaining + 1'b1;
                end
            end
        end
    end

    // result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out <= r_res;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    assign o_sts.idx_valid  = r_valid[r_idx];
    assign o_sts.idx_last   = (32'(r_idx) == 32'(dklt_pkg::NUM_KEYS - 1));
    assign o_sts.ticks_zero = (r_t == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

@@ rtl/decaying_key_level_table.sv @@
// Top level of the decaying key level table.
//
// Requests enter on the s_axis channel; tuser carries the command (level report,
// decay tick, read, unused). Each request gives exactly one result on the m_axis
// channel, with the action code in tuser. Registers are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// Report, read and unused commands take one level/tag RAM read; a report may then
// write the level and tag back. The result is registered in the decision state and
// then in the output register; the next request is taken only once the block is
// back in idle. A tick sweeps the valid bits: each stored key has its level loaded,
// decayed by one multiply per cycle, one per elapsed tick, then written back, or the
// key pruned if under threshold; then the removed/remaining counts go out.
// The result sits in an output register; the next request is accepted while it
// waits, and the block holds in its hand-off state until the receiver takes it.
// Synchronous reset empties the table (valid bits cleared), restores register
// defaults and drops any pending result; the RAMs need no clearing.
module decaying_key_level_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key[6:0], level_in[22:7], msg_tag[38:23], elapsed_ticks[42:39], zero[47:43]
    input  logic [dklt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd[1:0]
    input  logic [dklt_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // key_out[6:0], present[7], level_out[23:8], tag_out[39:24],
    // removed_count[47:40], remaining_count[55:48]
    output logic [dklt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // action[2:0]
    output logic [dklt_pkg::ACT_W-1:0]          m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dklt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dklt_pkg::FIELD_W-1:0]        i_cfg_data
);

    dklt_pkg::t_dp_ctl ctl;
    dklt_pkg::t_dp_sts sts;
    dklt_pkg::t_result res;
    dklt_pkg::t_cmd    in_cmd;

    assign in_cmd      = dklt_pkg::t_cmd'(s_axis_tuser);
    assign o_cfg_ready = 1'b1;

    dklt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (in_cmd),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    dklt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cmd       (in_cmd),
        .i_key       (s_axis_tdata[6:0]),
        .i_level     (s_axis_tdata[22:7]),
        .i_tag       (s_axis_tdata[38:23]),
        .i_ticks     (s_axis_tdata[42:39]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (res),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tuser = res.action;
    assign m_axis_tdata = {res.remaining, res.removed, res.tag, res.level,
                           res.present, res.key};

endmodule

@@ rtl/dklt_checker.sv @@
// Port-level checker for the decaying key level table, bound to the top level.
module dklt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dklt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [dklt_pkg::ACT_W-1:0]       m_axis_tuser
);

    logic is_tick;
    logic [dklt_pkg::CNT_W:0] cnt_sum;

    assign is_tick = (m_axis_tuser == dklt_pkg::ACT_TICK_DONE);
    assign cnt_sum = {1'b0, m_axis_tdata[47:40]} + {1'b0, m_axis_tdata[55:48]};

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && is_tick |-> m_axis_tdata[39:0] == '0
            && 32'(cnt_sum) <= 32'(dklt_pkg::NUM_KEYS))
        else $error("tick result fields inconsistent");

    a_entry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !is_tick |-> m_axis_tdata[55:40] == '0
            && (m_axis_tdata[7] || m_axis_tdata[39:8] == '0))
        else $error("entry result fields inconsistent");

    a_present_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == dklt_pkg::ACT_REMOVED
            || m_axis_tuser == dklt_pkg::ACT_TICK_DONE) |-> !m_axis_tdata[7])
        else $error("removed entry reported present");

endmodule

bind decaying_key_level_table dklt_checker u_dklt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
